FILE: rtl/pmiw_pkg.sv
// ----------------------------------------------------------------------------
// pmiw_pkg
// Shared types and constants of the periodic minimum-image wrap block.
// ----------------------------------------------------------------------------
package pmiw_pkg;

	// Internal datapath width; holds a displacement plus all tilt shifts.
	localparam int WD = 48;

	localparam int FW = 32; // field width of displacements
	localparam int LW = 27; // box length width
	localparam int TW = 28; // tilt width

	typedef enum logic [2:0] {
		REG_BOX_LEN_X = 3'd0,
		REG_BOX_LEN_Y = 3'd1,
		REG_BOX_LEN_Z = 3'd2,
		REG_TILT_XY   = 3'd3,
		REG_TILT_XZ   = 3'd4,
		REG_TILT_YZ   = 3'd5,
		REG_SKEWED    = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_X_FAR  = 2'd1,
		ST_Y_FAR  = 2'd2,
		ST_Z_FAR  = 2'd3
	} status_t;

	// One word in flight; components held in processing order.
	typedef struct packed {
		logic              valid;
		logic              fail;
		logic [1:0]        st;
		logic [2:0][WD-1:0] a;
	} item_t;

endpackage

FILE: rtl/pmiw_axis.sv
// ----------------------------------------------------------------------------
// pmiw_axis
// Wraps one component: range check, bit-per-stage image count, then the
// shift of the component and of the later components by the tilts.
// ----------------------------------------------------------------------------
module pmiw_axis import pmiw_pkg::*; #(
	parameter int SLOT       = 0,
	parameter int MAX_IMAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  item_t                in_item,
	input  logic [LW-1:0]        len,
	input  logic signed [TW-1:0] ta,
	input  logic signed [TW-1:0] tb,
	input  logic [1:0]           fail_code,
	output item_t                out_item
);

	localparam int QB = $clog2(MAX_IMAGES) + 1;
	localparam int NB = QB + 1;

	typedef struct packed {
		item_t         it;
		logic          neg;
		logic          gt;
		logic [WD-1:0] r;
		logic [QB-1:0] q;
	} work_t;

	work_t chk_nxt, chk_s1;
	work_t div_in  [QB];
	work_t div_nxt [QB];
	work_t div_s2  [QB];
	item_t app_nxt, app_s3;

	logic signed [WD-1:0] d, m, lim, lw;

	always_comb begin
		d   = $signed(in_item.a[SLOT]);
		m   = (d < 0) ? -d : d;
		lw  = $signed(WD'(len));
		lim = lw * $signed(WD'(MAX_IMAGES));
		chk_nxt     = '0;
		chk_nxt.it  = in_item;
		chk_nxt.neg = d < 0;
		chk_nxt.gt  = (m <<< 1) > lw;
		// r = 2|d| - L - 1; image count is r / 2L + 1 when 2|d| > L
		chk_nxt.r   = WD'((m <<< 1) - lw - 1);
		if (in_item.valid && !in_item.fail && (m > lim)) begin
			chk_nxt.it.fail = 1'b1;
			chk_nxt.it.st   = fail_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= '0;
		end else if (en) begin
			chk_s1 <= chk_nxt;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [WD-1:0] dv;
		if (j == 0) begin : g_first
			assign div_in[j] = chk_s1;
		end else begin : g_next
			assign div_in[j] = div_s2[j-1];
		end
		always_comb begin
			dv         = WD'(len) << (B + 1);
			div_nxt[j] = div_in[j];
			if (div_in[j].r >= dv) begin
				div_nxt[j].r    = div_in[j].r - dv;
				div_nxt[j].q[B] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s2[j] <= '0;
			end else if (en) begin
				div_s2[j] <= div_nxt[j];
			end
		end
	end

	work_t                  w;
	logic [NB-1:0]          n;
	logic signed [WD-1:0]   dl, sh, cur;

	always_comb begin
		w       = div_s2[QB-1];
		n       = NB'(w.q) + NB'(1);
		app_nxt = w.it;
		if (w.it.valid && !w.it.fail && w.gt) begin
			for (int i = 0; i < 3; i++) begin
				cur = $signed(w.it.a[i]);
				if (i == SLOT) begin
					dl = $signed({1'b0, n}) * $signed({1'b0, len});
				end else if (i == SLOT + 1) begin
					dl = $signed({1'b0, n}) * ta;
				end else if (i == SLOT + 2) begin
					dl = $signed({1'b0, n}) * tb;
				end else begin
					dl = '0;
				end
				sh = w.neg ? cur + dl : cur - dl;
				app_nxt.a[i] = sh;
			end
		end else begin
			dl  = '0;
			sh  = '0;
			cur = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_s3 <= '0;
		end else if (en) begin
			app_s3 <= app_nxt;
		end
	end

	assign out_item = app_s3;

endmodule

FILE: rtl/periodic_minimum_image_wrap.sv
// ----------------------------------------------------------------------------
// periodic_minimum_image_wrap
// Minimum-image wrap of a pair displacement in an orthogonal or triclinic box.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is taken every cycle; the whole pipeline holds
// while a result waits at the output. Each axis has
// a range-check stage, one stage per image-count bit and a shift stage.
// Configuration
// goes through the APB port and may be changed only with the pipeline empty.
module periodic_minimum_image_wrap import pmiw_pkg::*; #(
	parameter int MAX_IMAGES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [FW-1:0]  disp_x,
	input  logic signed [FW-1:0]  disp_y,
	input  logic signed [FW-1:0]  disp_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [FW-1:0]  wrapped_x,
	output logic signed [FW-1:0]  wrapped_y,
	output logic signed [FW-1:0]  wrapped_z,
	output logic [1:0]            status
);

	logic [LW-1:0]        len_x_q, len_y_q, len_z_q;
	logic signed [TW-1:0] txy_q, txz_q, tyz_q;
	logic                 skewed_q;
	reg_idx_t             idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_x_q  <= LW'(65536);
			len_y_q  <= LW'(65536);
			len_z_q  <= LW'(65536);
			txy_q    <= '0;
			txz_q    <= '0;
			tyz_q    <= '0;
			skewed_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_BOX_LEN_X: len_x_q  <= pwdata[LW-1:0];
				REG_BOX_LEN_Y: len_y_q  <= pwdata[LW-1:0];
				REG_BOX_LEN_Z: len_z_q  <= pwdata[LW-1:0];
				REG_TILT_XY:   txy_q    <= $signed(pwdata[TW-1:0]);
				REG_TILT_XZ:   txz_q    <= $signed(pwdata[TW-1:0]);
				REG_TILT_YZ:   tyz_q    <= $signed(pwdata[TW-1:0]);
				REG_SKEWED:    skewed_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BOX_LEN_X: prdata = 32'(len_x_q);
			REG_BOX_LEN_Y: prdata = 32'(len_y_q);
			REG_BOX_LEN_Z: prdata = 32'(len_z_q);
			REG_TILT_XY:   prdata = 32'(txy_q);
			REG_TILT_XZ:   prdata = 32'(txz_q);
			REG_TILT_YZ:   prdata = 32'(tyz_q);
			REG_SKEWED:    prdata = {31'd0, skewed_q};
			default:       prdata = '0;
		endcase
	end

	logic en;
	item_t in_nxt, in_s1, ax0, ax1, ax2, out_nxt, out_s2;

	assign en       = !out_s2.valid || out_ready;
	assign in_ready = en;

	// slot order: orthogonal x,y,z; triclinic z,y,x
	always_comb begin
		in_nxt       = '0;
		in_nxt.valid = in_valid;
		in_nxt.a[1]  = WD'(disp_y);
		in_nxt.a[0]  = skewed_q ? WD'(disp_z) : WD'(disp_x);
		in_nxt.a[2]  = skewed_q ? WD'(disp_x) : WD'(disp_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else if (en) begin
			in_s1 <= in_nxt;
		end
	end

	logic [LW-1:0]        len0, len2;
	logic signed [TW-1:0] t0a, t0b, t1a;
	logic [1:0]           code0, code2;

	assign len0  = skewed_q ? len_z_q : len_x_q;
	assign len2  = skewed_q ? len_x_q : len_z_q;
	assign t0a   = skewed_q ? tyz_q : '0;
	assign t0b   = skewed_q ? txz_q : '0;
	assign t1a   = skewed_q ? txy_q : '0;
	assign code0 = skewed_q ? ST_Z_FAR : ST_X_FAR;
	assign code2 = skewed_q ? ST_X_FAR : ST_Z_FAR;

	pmiw_axis #(.SLOT(0), .MAX_IMAGES(MAX_IMAGES)) u_ax0 (
		.clk, .arst_n, .en, .in_item(in_s1), .len(len0), .ta(t0a), .tb(t0b),
		.fail_code(code0), .out_item(ax0)
	);
	pmiw_axis #(.SLOT(1), .MAX_IMAGES(MAX_IMAGES)) u_ax1 (
		.clk, .arst_n, .en, .in_item(ax0), .len(len_y_q), .ta(t1a), .tb('0),
		.fail_code(ST_Y_FAR), .out_item(ax1)
	);
	pmiw_axis #(.SLOT(2), .MAX_IMAGES(MAX_IMAGES)) u_ax2 (
		.clk, .arst_n, .en, .in_item(ax1), .len(len2), .ta('0), .tb('0),
		.fail_code(code2), .out_item(ax2)
	);

	always_comb begin
		out_nxt = ax2;
		if (ax2.fail) begin
			out_nxt.a = '0;
		end else begin
			out_nxt.st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else if (en) begin
			out_s2 <= out_nxt;
		end
	end

	assign out_valid = out_s2.valid;
	assign status    = out_s2.st;
	assign wrapped_y = $signed(out_s2.a[1][FW-1:0]);
	assign wrapped_x = skewed_q ? $signed(out_s2.a[2][FW-1:0]) : $signed(out_s2.a[0][FW-1:0]);
	assign wrapped_z = skewed_q ? $signed(out_s2.a[0][FW-1:0]) : $signed(out_s2.a[2][FW-1:0]);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (out_s2.a == '0))
		else $error("error word carries nonzero displacement");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_s2))
		else $error("stalled result changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready out of step with output stall");

endmodule

FILE: tb/pmiw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmiw_checker
// Watches the config port and both streams of the minimum-image wrap block,
// predicts each wrapped displacement and compares it with the block's output.
// ----------------------------------------------------------------------------
module pmiw_checker import pmiw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [FW-1:0] disp_x,
	input  logic signed [FW-1:0] disp_y,
	input  logic signed [FW-1:0] disp_z,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [FW-1:0] wrapped_x,
	input  logic signed [FW-1:0] wrapped_y,
	input  logic signed [FW-1:0] wrapped_z,
	input  logic [1:0]           status,
	output int                   errors,
	output int                   pending
);

	localparam longint IMAGES = 16;

	typedef struct {
		logic [FW-1:0] x;
		logic [FW-1:0] y;
		logic [FW-1:0] z;
		status_t       st;
	} wrapped_t;

	wrapped_t wrapped_q[$];

	longint len_x, len_y, len_z;
	longint t_xy, t_xz, t_yz;
	bit     skewed;

	function automatic longint magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	// range check then fold one axis; a and b follow by their tilts
	function automatic bit fold_axis(inout longint d, input longint l,
			inout longint a, input longint ta, inout longint b, input longint tb);
		if (magn(d) > IMAGES * l)
			return 0;
		for (int i = 0; i < IMAGES + 2 && 2 * magn(d) > l; i++) begin
			if (d < 0) begin
				d += l; a += ta; b += tb;
			end else begin
				d -= l; a -= ta; b -= tb;
			end
		end
		return 1;
	endfunction

	function automatic wrapped_t min_image(longint x, longint y, longint z);
		wrapped_t r;
		longint   dummy;
		status_t  st;
		dummy = 0;
		st = ST_OK;
		if (!skewed) begin
			if (!fold_axis(x, len_x, dummy, 0, dummy, 0)) st = ST_X_FAR;
			else if (!fold_axis(y, len_y, dummy, 0, dummy, 0)) st = ST_Y_FAR;
			else if (!fold_axis(z, len_z, dummy, 0, dummy, 0)) st = ST_Z_FAR;
		end else begin
			if (!fold_axis(z, len_z, y, t_yz, x, t_xz)) st = ST_Z_FAR;
			else if (!fold_axis(y, len_y, x, t_xy, dummy, 0)) st = ST_Y_FAR;
			else if (!fold_axis(x, len_x, dummy, 0, dummy, 0)) st = ST_X_FAR;
		end
		if (st != ST_OK) begin
			x = 0; y = 0; z = 0;
		end
		r.x = x[FW-1:0];
		r.y = y[FW-1:0];
		r.z = z[FW-1:0];
		r.st = st;
		return r;
	endfunction

	assign pending = wrapped_q.size();

	always @(posedge clk or negedge arst_n) begin
		wrapped_t e;
		if (!arst_n) begin
			len_x = 65536; len_y = 65536; len_z = 65536;
			t_xy = 0; t_xz = 0; t_yz = 0;
			skewed = 0;
			errors = 0;
			wrapped_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
				REG_BOX_LEN_X: len_x = longint'(pwdata[LW-1:0]);
				REG_BOX_LEN_Y: len_y = longint'(pwdata[LW-1:0]);
				REG_BOX_LEN_Z: len_z = longint'(pwdata[LW-1:0]);
				REG_TILT_XY:   t_xy = longint'(signed'(pwdata[TW-1:0]));
				REG_TILT_XZ:   t_xz = longint'(signed'(pwdata[TW-1:0]));
				REG_TILT_YZ:   t_yz = longint'(signed'(pwdata[TW-1:0]));
				REG_SKEWED:    skewed = pwdata[0];
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (wrapped_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: x=%h y=%h z=%h st=%0d",
							wrapped_x, wrapped_y, wrapped_z, status);
				end else begin
					e = wrapped_q.pop_front();
					if (wrapped_x !== e.x || wrapped_y !== e.y ||
							wrapped_z !== e.z || status !== e.st) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
								e.x, e.y, e.z, e.st,
								wrapped_x, wrapped_y, wrapped_z, status);
					end
				end
			end
			if (in_valid && in_ready)
				wrapped_q.push_back(min_image(longint'(disp_x), longint'(disp_y),
					longint'(disp_z)));
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives displacement words and box settings into the minimum-image wrap
// block under random stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import pmiw_pkg::*;

	localparam int LATENCY = 23;
	localparam int WATCHDOG = 20000;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [FW-1:0] disp_x, disp_y, disp_z;
	logic signed [FW-1:0] wrapped_x, wrapped_y, wrapped_z;
	logic [1:0] status;
	int errors, pending;

	bit quiet;      // no idling on either side
	bit hold_req;   // receiver: one long hold-off
	int idle_cnt;

	longint cur_lx, cur_ly, cur_lz;

	periodic_minimum_image_wrap uut (.*);

	pmiw_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with nothing accepted on either stream
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
				out_ready <= 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1;
			end else
				out_ready <= 1;
		end
	end

	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_box(longint lx, longint ly, longint lz, longint txy,
			longint txz, longint tyz, bit sk);
		drain();
		cfg_write(REG_BOX_LEN_X, lx[31:0]);
		cfg_write(REG_BOX_LEN_Y, ly[31:0]);
		cfg_write(REG_BOX_LEN_Z, lz[31:0]);
		cfg_write(REG_TILT_XY, txy[31:0]);
		cfg_write(REG_TILT_XZ, txz[31:0]);
		cfg_write(REG_TILT_YZ, tyz[31:0]);
		cfg_write(REG_SKEWED, {31'd0, sk});
		cur_lx = lx; cur_ly = ly; cur_lz = lz;
	endtask

	// optional idle gap first, then offer the word until it is taken
	task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1;
		disp_x <= x; disp_y <= y; disp_z <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] rand_comp(longint l);
		longint k, d;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		k = longint'($urandom_range(0, 40)) - 20;
		d = k * l + longint'($urandom_range(0, l)) - l / 2;
		if (d > 64'sh7FFFFFFF || d < -64'sh80000000)
			return $urandom;
		return d[31:0];
	endfunction

	task automatic random_words(int n);
		repeat (n)
			send_word(rand_comp(cur_lx), rand_comp(cur_ly), rand_comp(cur_lz));
		in_valid <= 0;
	endtask

	task automatic directed_words();
		longint l;
		l = cur_lx;
		send_word(0, 0, 0);
		send_word(32'h7FFFFFFF, 0, 0);
		send_word(32'h80000000, 0, 0);
		send_word(0, 32'h7FFFFFFF, 32'h80000000);
		// exactly half: untouched
		send_word(32'(l / 2), 32'(-(l / 2)), 32'(l / 2));
		// just over half
		send_word(32'(l / 2 + 1), 32'(-(l / 2) - 1), 32'(l / 2 + 1));
		// edge of range check
		send_word(32'(16 * l), 32'(-16 * l), 32'(16 * l));
		send_word(32'(16 * l + 1), 0, 0);                   // x too far
		send_word(0, 32'(-16 * l - 1), 0);                  // y too far
		send_word(0, 0, 32'(16 * l + 1));                   // z too far
		// first failing axis wins
		send_word(32'(16 * l + 1), 32'(16 * l + 1), 32'(16 * l + 1));
		send_word(32'(3 * l + 7), 32'(-5 * l - 9), 32'(11 * l));
		in_valid <= 0;
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; disp_x = 0; disp_y = 0; disp_z = 0;
		quiet = 0; hold_req = 0; idle_cnt = 0;
		cur_lx = 65536; cur_ly = 65536; cur_lz = 65536;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		directed_words();
		set_box(65536, 65536, 65536, 32768, -32768, 65536, 1);
		directed_words();

		set_box(65536, 98304, 131072, 0, 0, 0, 0);
		random_words(100);
		// long receiver hold-off while the sender keeps offering words
		hold_req = 1;
		random_words(100);
		// sender pause until everything is out
		while (pending != 0) @(posedge clk);
		set_box(134217727, 134217727, 134217727, 134217727, -134217728,
			134217727, 1);
		random_words(80);
		set_box(134217727, 65536, 134217727, -134217728, 134217727,
			-134217728, 1);
		random_words(80);
		repeat (3) begin
			set_box(longint'($urandom_range(65536, 1 << 22)),
				longint'($urandom_range(65536, 1 << 22)),
				longint'($urandom_range(65536, 1 << 22)),
				longint'($urandom_range(0, 1 << 23)) - (1 << 22),
				longint'($urandom_range(0, 1 << 23)) - (1 << 22),
				longint'($urandom_range(0, 1 << 23)) - (1 << 22),
				1'($urandom_range(0, 1)));
			random_words(120);
		end
		set_box(200000, 300000, 150000, 50000, -70000, 90000, 1);
		quiet = 1;
		random_words(100);

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/pmiw_pkg.sv
rtl/pmiw_axis.sv
rtl/periodic_minimum_image_wrap.sv
tb/pmiw_checker.sv
tb/testbench.sv
